// ===== rtl/parking_maneuver_sequencer_macros.svh =====
// assertion macros for the parking manoeuvre sequencer
`ifndef PARKING_MANEUVER_SEQUENCER_MACROS_SVH
`define PARKING_MANEUVER_SEQUENCER_MACROS_SVH

// condition must never hold outside reset
`define PMS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define PMS_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define PMS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/pms_pkg.sv =====
// shared types, codes and constants of the parking manoeuvre sequencer
package pms_pkg;

	// action codes
	typedef enum logic [2:0] {
		ACT_STOP    = 3'd0,
		ACT_FORWARD = 3'd1,
		ACT_REVERSE = 3'd2,
		ACT_LEFT    = 3'd3,
		ACT_RIGHT   = 3'd4
	} action_t;

	// drive modes
	typedef enum logic [1:0] {
		MODE_NORMAL  = 2'd0,
		MODE_TO_PARK = 2'd1,
		MODE_PARK    = 2'd2
	} mode_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_ROTATION    = 3'd0,
		REG_FIRST_SPOT  = 3'd1,
		REG_SECOND_SPOT = 3'd2,
		REG_CHECK       = 3'd3,
		REG_ENTER       = 3'd4,
		REG_WAIT        = 3'd5,
		REG_EXIT        = 3'd6
	} reg_index_t;

	localparam int REG_W   = 7;
	localparam int IDX_W   = 3;
	localparam int S_DATA_W = 40;
	localparam int M_DATA_W = 32;

	// register reset values
	localparam logic [REG_W-1:0] RST_ROTATION    = 7'd74;
	localparam logic [REG_W-1:0] RST_FIRST_SPOT  = 7'd8;
	localparam logic [REG_W-1:0] RST_SECOND_SPOT = 7'd11;
	localparam logic [REG_W-1:0] RST_CHECK       = 7'd11;
	localparam logic [REG_W-1:0] RST_ENTER       = 7'd5;
	localparam logic [REG_W-1:0] RST_WAIT        = 7'd15;
	localparam logic [REG_W-1:0] RST_EXIT        = 7'd11;

	// frame classification constants
	localparam logic [7:0] DASH_SPOT_A = 8'd7;
	localparam logic [7:0] DASH_SPOT_B = 8'd8;
	localparam logic [7:0] DASH_HOLD   = 8'd6;
	localparam logic [7:0] LARGE_SPOT  = 8'd0;
	localparam logic [7:0] LARGE_HOLD  = 8'd1;
	localparam logic [7:0] STOP_ONE    = 8'd1;
	localparam logic [9:0] ROW_LO      = 10'd180;
	localparam logic [9:0] ROW_HI      = 10'd250;

	// speeds in thousandths
	localparam logic signed [6:0] FWD_SPEED  = 7'sd60;
	localparam logic signed [8:0] TURN_SPEED = 9'sd200;

	// configuration register file
	typedef struct packed {
		logic [REG_W-1:0] rotation;
		logic [REG_W-1:0] first_spot;
		logic [REG_W-1:0] second_spot;
		logic [REG_W-1:0] check;
		logic [REG_W-1:0] enter;
		logic [REG_W-1:0] wait_n;
		logic [REG_W-1:0] exit_n;
	} cfg_regs_t;

	// per-frame classification flags
	typedef struct packed {
		logic dash_up;
		logic dash_hold;
		logic large_up;
		logic large_hold;
		logic stop_any;
		logic exit_ok;
	} cls_t;

	// queue write side
	typedef struct packed {
		logic push;
		cls_t cls;
	} q_wr_t;

	// queue read side
	typedef struct packed {
		logic valid;
		cls_t cls;
	} q_rd_t;

	// manoeuvre phases, one-hot
	typedef enum logic [10:0] {
		PH_FIRST_SPOT  = 11'b000_0000_0001,
		PH_TURN_IN     = 11'b000_0000_0010,
		PH_CHECK       = 11'b000_0000_0100,
		PH_ENTER       = 11'b000_0000_1000,
		PH_WAIT        = 11'b000_0001_0000,
		PH_EXIT        = 11'b000_0010_0000,
		PH_TURN_BACK   = 11'b000_0100_0000,
		PH_DONE        = 11'b000_1000_0000,
		PH_TURN_AWAY   = 11'b001_0000_0000,
		PH_SECOND_SPOT = 11'b010_0000_0000,
		PH_TURN_SECOND = 11'b100_0000_0000
	} phase_t;

	// phase number reported in the result
	function automatic logic [3:0] phase_num(input phase_t ph);
		logic [3:0] n;
		case (ph)
			PH_FIRST_SPOT:  n = 4'd0;
			PH_TURN_IN:     n = 4'd1;
			PH_CHECK:       n = 4'd2;
			PH_ENTER:       n = 4'd3;
			PH_WAIT:        n = 4'd4;
			PH_EXIT:        n = 4'd5;
			PH_TURN_BACK:   n = 4'd6;
			PH_DONE:        n = 4'd7;
			PH_TURN_AWAY:   n = 4'd8;
			PH_SECOND_SPOT: n = 4'd9;
			PH_TURN_SECOND: n = 4'd10;
			default:        n = 4'd0;
		endcase
		return n;
	endfunction

endpackage

// ===== rtl/parking_maneuver_sequencer.sv =====
// top level of the parking manoeuvre sequencer
// path: input transaction to the front stage register, then the queue, then the result register (m_tvalid)
// throughput: one frame per cycle while results are taken (m_tready high), set by the phase and counter update
// in the back end; the front stage and the queue add latency, not stalls
// reset: arst_n clears phase, counter, queue and result valid at once and loads the
// register defaults; no clearing pass, input is accepted as soon as reset is released
`include "parking_maneuver_sequencer_macros.svh"

module parking_maneuver_sequencer
	import pms_pkg::*;
#(
	parameter int COUNT_BITS  = 8,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	// dash_count, large_dash_count, stop_line_count, stop_line_row, zero fill
	input  logic [S_DATA_W-1:0] s_tdata,
	output logic                m_tvalid,
	input  logic                m_tready,
	// action_code, drive_mode, sequence_state, forward_speed, turn_speed,
	// drive_valid, zero fill
	output logic [M_DATA_W-1:0] m_tdata,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [IDX_W-1:0]    cfg_index,
	input  logic [REG_W-1:0]    cfg_data
);

	cfg_regs_t cfg_q;
	q_wr_t     q_wr;
	q_rd_t     q_rd;
	logic      q_wr_ready;
	logic      pop;

	// configuration writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rotation    <= RST_ROTATION;
			cfg_q.first_spot  <= RST_FIRST_SPOT;
			cfg_q.second_spot <= RST_SECOND_SPOT;
			cfg_q.check       <= RST_CHECK;
			cfg_q.enter       <= RST_ENTER;
			cfg_q.wait_n      <= RST_WAIT;
			cfg_q.exit_n      <= RST_EXIT;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_index_t'(cfg_index))
				REG_ROTATION:    cfg_q.rotation    <= cfg_data;
				REG_FIRST_SPOT:  cfg_q.first_spot  <= cfg_data;
				REG_SECOND_SPOT: cfg_q.second_spot <= cfg_data;
				REG_CHECK:       cfg_q.check       <= cfg_data;
				REG_ENTER:       cfg_q.enter       <= cfg_data;
				REG_WAIT:        cfg_q.wait_n      <= cfg_data;
				REG_EXIT:        cfg_q.exit_n      <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// front end
	pms_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.wr       (q_wr),
		.wr_ready (q_wr_ready)
	);

	// queue between the two sides
	pms_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (q_wr),
		.wr_ready (q_wr_ready),
		.rd       (q_rd),
		.pop      (pop)
	);

	// back end
	pms_back #(
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.rd       (q_rd),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// checks
	`PMS_ASSERT_NEVER(a_no_push_full, clk, arst_n, q_wr.push && !q_wr_ready, "push into full queue")
	`PMS_ASSERT_IMPLIES(a_stall_cause, clk, arst_n, !s_tready, !q_wr_ready, "input stalled with queue room")
	`PMS_ASSERT_IMPLIES(a_drive_valid, clk, arst_n, m_tvalid, m_tdata[25] == (m_tdata[4:3] == MODE_PARK), "drive_valid disagrees with mode")
	`PMS_ASSERT_NEXT(a_pop_result, clk, arst_n, pop, m_tvalid, "popped frame gave no result")

endmodule

// ===== rtl/pms_front.sv =====
// front end: accepts frame summaries and classifies them into flags
module pms_front
	import pms_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	// dash_count, large_dash_count, stop_line_count, stop_line_row, zero fill
	input  logic [S_DATA_W-1:0] s_tdata,
	output q_wr_t               wr,
	input  logic                wr_ready
);

	logic       valid_s1;
	cls_t       cls_s1;
	logic [7:0] dash;
	logic [7:0] large_cnt;
	logic [7:0] stops;
	logic [9:0] row;
	cls_t       cls_c;

	assign dash      = s_tdata[7:0];
	assign large_cnt = s_tdata[15:8];
	assign stops     = s_tdata[23:16];
	assign row       = s_tdata[33:24];

	// classify the frame
	always_comb begin
		cls_c.dash_up    = (dash == DASH_SPOT_A) || (dash == DASH_SPOT_B);
		cls_c.dash_hold  = (dash == DASH_HOLD);
		cls_c.large_up   = (large_cnt == LARGE_SPOT);
		cls_c.large_hold = (large_cnt == LARGE_HOLD);
		cls_c.stop_any   = (stops != 8'd0);
		cls_c.exit_ok    = (stops == STOP_ONE) && (row > ROW_LO) && (row < ROW_HI);
	end

	// stage register drains into the queue
	assign s_tready = !valid_s1 || wr_ready;
	assign wr.push  = valid_s1 && wr_ready;
	assign wr.cls   = cls_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cls_s1 <= cls_c;
		end
	end

endmodule

// ===== rtl/pms_queue.sv =====
// short queue of classified frames between front and back end
module pms_queue
	import pms_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic  clk,
	input  logic  arst_n,
	input  q_wr_t wr,
	output logic  wr_ready,
	output q_rd_t rd,
	input  logic  pop
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	cls_t             mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign wr_ready = (count_q != CNT_W'(DEPTH));
	assign rd.valid = (count_q != '0);
	assign rd.cls   = mem[rd_ptr_q];
	assign do_wr    = wr.push && wr_ready;
	assign do_rd    = pop && rd.valid;

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem[wr_ptr_q] <= wr.cls;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/pms_back.sv =====
// back end: manoeuvre sequencer with debounce counter and result register
module pms_back
	import pms_pkg::*;
#(
	parameter int COUNT_BITS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cfg_regs_t           cfg,
	input  q_rd_t               rd,
	output logic                pop,
	output logic                m_tvalid,
	input  logic                m_tready,
	// action_code, drive_mode, sequence_state, forward_speed, turn_speed,
	// drive_valid, zero fill
	output logic [M_DATA_W-1:0] m_tdata
);

	localparam int CW   = COUNT_BITS + 1;
	localparam int CMPW = (CW > REG_W + 1) ? CW : REG_W + 1;
	localparam logic signed [CW-1:0] CNT_MAX = {1'b0, {COUNT_BITS{1'b1}}};
	localparam logic signed [CW-1:0] CNT_MIN = {1'b1, {COUNT_BITS{1'b0}}};
	localparam logic signed [CW-1:0] CNT_ONE = CW'(1);

	phase_t                 phase_q;
	phase_t                 phase_n;
	logic signed [CW-1:0]   cnt_q;
	logic signed [CW-1:0]   cnt_n;
	action_t                act;
	mode_t                  mode;
	logic signed [6:0]      fwd;
	logic signed [8:0]      trn;
	logic                   out_valid_q;
	logic [M_DATA_W-1:0]    out_data_q;

	// saturating counter steps
	function automatic logic signed [CW-1:0] cnt_up(input logic signed [CW-1:0] c);
		return (c == CNT_MAX) ? c : c + CNT_ONE;
	endfunction

	function automatic logic signed [CW-1:0] cnt_down(input logic signed [CW-1:0] c);
		return (c == CNT_MIN) ? c : c - CNT_ONE;
	endfunction

	// threshold compares in a common signed width
	function automatic logic cnt_ge(input logic signed [CW-1:0] c, input logic [REG_W-1:0] r);
		logic signed [CMPW-1:0] cx;
		logic signed [CMPW-1:0] rx;
		cx = CMPW'(c);
		rx = signed'(CMPW'(r));
		return cx >= rx;
	endfunction

	function automatic logic cnt_gt(input logic signed [CW-1:0] c, input logic [REG_W-1:0] r);
		logic signed [CMPW-1:0] cx;
		logic signed [CMPW-1:0] rx;
		cx = CMPW'(c);
		rx = signed'(CMPW'(r));
		return cx > rx;
	endfunction

	function automatic logic cnt_le_neg(input logic signed [CW-1:0] c,
			input logic [REG_W-1:0] r);
		logic signed [CMPW-1:0] cx;
		logic signed [CMPW-1:0] rx;
		cx = CMPW'(c);
		rx = -signed'(CMPW'(r));
		return cx <= rx;
	endfunction

	// output register frees as soon as the current result is taken
	assign pop      = rd.valid && (!out_valid_q || m_tready);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// phase and counter update for one frame
	always_comb begin
		cnt_n   = cnt_q;
		phase_n = phase_q;
		act     = ACT_STOP;
		mode    = MODE_PARK;
		case (phase_q)
			PH_FIRST_SPOT: begin
				act  = ACT_FORWARD;
				mode = MODE_TO_PARK;
				if (rd.cls.dash_up) begin
					cnt_n = cnt_up(cnt_q);
				end else if (!rd.cls.dash_hold) begin
					cnt_n = '0;
				end
				if (cnt_ge(cnt_n, cfg.first_spot)) begin
					cnt_n   = '0;
					phase_n = PH_TURN_IN;
				end
			end
			PH_TURN_IN: begin
				act   = ACT_RIGHT;
				cnt_n = cnt_up(cnt_q);
				if (cnt_gt(cnt_n, cfg.rotation)) begin
					cnt_n   = '0;
					phase_n = PH_CHECK;
				end
			end
			PH_CHECK: begin
				act   = ACT_STOP;
				cnt_n = rd.cls.stop_any ? cnt_up(cnt_q) : cnt_down(cnt_q);
				if (cnt_ge(cnt_n, cfg.check)) begin
					cnt_n   = '0;
					phase_n = PH_ENTER;
				end else if (cnt_le_neg(cnt_n, cfg.check)) begin
					cnt_n   = '0;
					phase_n = PH_TURN_AWAY;
				end
			end
			PH_ENTER: begin
				act   = ACT_FORWARD;
				cnt_n = rd.cls.stop_any ? '0 : cnt_up(cnt_q);
				if (cnt_ge(cnt_n, cfg.enter)) begin
					cnt_n   = '0;
					phase_n = PH_WAIT;
				end
			end
			PH_WAIT: begin
				act   = ACT_STOP;
				cnt_n = cnt_up(cnt_q);
				if (cnt_ge(cnt_n, cfg.wait_n)) begin
					cnt_n   = '0;
					phase_n = PH_EXIT;
				end
			end
			PH_EXIT: begin
				act   = ACT_REVERSE;
				cnt_n = rd.cls.exit_ok ? cnt_up(cnt_q) : '0;
				if (cnt_ge(cnt_n, cfg.exit_n)) begin
					cnt_n   = '0;
					phase_n = PH_TURN_BACK;
				end
			end
			PH_TURN_BACK: begin
				act   = ACT_LEFT;
				cnt_n = cnt_up(cnt_q);
				if (cnt_gt(cnt_n, cfg.rotation)) begin
					cnt_n   = '0;
					phase_n = PH_DONE;
				end
			end
			PH_DONE: begin
				act  = ACT_FORWARD;
				mode = MODE_NORMAL;
			end
			PH_TURN_AWAY: begin
				act   = ACT_LEFT;
				cnt_n = cnt_up(cnt_q);
				if (cnt_gt(cnt_n, cfg.rotation)) begin
					cnt_n   = '0;
					phase_n = PH_SECOND_SPOT;
				end
			end
			PH_SECOND_SPOT: begin
				act  = ACT_FORWARD;
				mode = MODE_TO_PARK;
				if (rd.cls.large_up) begin
					cnt_n = cnt_up(cnt_q);
				end else if (!rd.cls.large_hold) begin
					cnt_n = '0;
				end
				if (cnt_ge(cnt_n, cfg.second_spot)) begin
					cnt_n   = '0;
					phase_n = PH_TURN_SECOND;
				end
			end
			PH_TURN_SECOND: begin
				act   = ACT_RIGHT;
				cnt_n = cnt_up(cnt_q);
				if (cnt_gt(cnt_n, cfg.rotation)) begin
					cnt_n   = '0;
					phase_n = PH_ENTER;
				end
			end
			default: begin
				act  = ACT_STOP;
				mode = MODE_PARK;
			end
		endcase
	end

	// speeds that belong to the action
	always_comb begin
		fwd = '0;
		trn = '0;
		case (act)
			ACT_FORWARD: fwd = FWD_SPEED;
			ACT_REVERSE: fwd = -FWD_SPEED;
			ACT_LEFT:    trn = TURN_SPEED;
			ACT_RIGHT:   trn = -TURN_SPEED;
			default: begin
				fwd = '0;
				trn = '0;
			end
		endcase
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_FIRST_SPOT;
			cnt_q         <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (pop) begin
				phase_q       <= phase_n;
				cnt_q         <= cnt_n;
				out_valid_q   <= 1'b1;
			end else if (m_tready) begin
				out_valid_q   <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (pop) begin
			out_data_q <= {6'd0, (mode == MODE_PARK), trn, fwd, phase_num(phase_n),
				mode, act};
		end
	end

endmodule
